// ===== rtl/rc_channel_trim_and_frame_defines.svh =====
// assertion helpers for the checker file
`ifndef RC_CHANNEL_TRIM_AND_FRAME_DEFINES_SVH
`define RC_CHANNEL_TRIM_AND_FRAME_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RCTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rctf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RCTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rctf assertion failed");

`endif

// ===== rtl/rctf_pkg.sv =====
package rctf_pkg;

	localparam int CHANNELS_DEFAULT = 2;

	// configuration port
	localparam int CFG_DATA_W = 16;
	localparam logic REG_NOISE_TOL = 1'b0;
	localparam logic REG_DEBOUNCE  = 1'b1;

	localparam logic [9:0]  NOISE_TOL_RESET = 10'd10;
	localparam logic [15:0] DEBOUNCE_RESET  = 16'd50;

	// position and trim limits
	localparam logic signed [12:0] POS_TOP    = 13'sd1023;
	localparam logic signed [12:0] POS_BOTTOM = 13'sd0;
	localparam logic signed [11:0] TRIM_MAX   = 12'sd2047;
	localparam logic signed [11:0] TRIM_MIN   = -12'sd2048;

	// frame layout
	localparam logic [7:0] LETTER_BASE = 8'h41;
	localparam logic [1:0] BYTE_LETTER = 2'd0;
	localparam logic [1:0] BYTE_LOW    = 2'd1;
	localparam logic [1:0] BYTE_HIGH   = 2'd2;

endpackage

// ===== rtl/rc_channel_trim_and_frame.sv =====
// flow: an accepted request is registered into the input stage and evaluated there; its frame
//   (if any) is loaded as it leaves that stage; bytes are shown one per cycle when not stalled
// throughput: one request per cycle when it emits nothing and none waits ahead of it; a
//   request that emits a frame waits in the evaluation stage while an earlier frame still
//   drains, so frames leave the single 8-bit output port back to back, three bytes each
// reset: arst_n clears all channel state, the frame buffer and the input stage valid
module rc_channel_trim_and_frame import rctf_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic                  channel,
	input  logic                  button,
	input  logic [9:0]            pot_value,
	input  logic                  button_level,
	input  logic [31:0]           time_ms,
	// frame byte channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            frame_byte,
	output logic                  last
);

	// the channel field is one bit wide, so at most two channels can ever be addressed
	localparam int USED = (CHANNELS < 2) ? CHANNELS : 2;
	localparam int KEYS = 2 * USED;

	// configuration registers, reset to noise_tolerance = 10 and debounce_ms = 50
	logic [9:0]  noise_tol_q;
	logic [15:0] debounce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_tol_q <= NOISE_TOL_RESET;
			debounce_q  <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOISE_TOL: noise_tol_q <= cfg_data[9:0];
				REG_DEBOUNCE:  debounce_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// input stage
	logic        valid_s1;
	logic        mode_s1;
	logic        channel_s1;
	logic        button_s1;
	logic [9:0]  pot_s1;
	logic        level_s1;
	logic [31:0] time_s1;

	logic in_accept;
	logic fire;

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1    <= mode;
			channel_s1 <= channel;
			button_s1  <= button;
			pot_s1     <= pot_value;
			level_s1   <= button_level;
			time_s1    <= time_ms;
		end
	end

	// per-channel state
	logic        [9:0]  joy_q   [USED];
	logic signed [11:0] trim_q  [USED];
	logic signed [12:0] pos_q   [USED];
	// per channel and button state, keyed by {channel, button}
	logic               stable_q [KEYS];
	logic               prev_q   [KEYS];
	logic        [31:0] change_q [KEYS];

	logic               ch_ok;
	logic [1:0]         key;
	logic [9:0]         joy_cur;
	logic signed [11:0] trim_cur;
	logic signed [12:0] pos_cur;
	logic signed [10:0] joy_diff;
	logic [10:0]        joy_dist;
	logic               joy_move;
	logic               level_changed;
	logic [31:0]        elapsed;
	logic               settled;
	logic               new_level;
	logic               press;
	logic signed [11:0] trim_adj;
	logic [9:0]         joy_next;
	logic signed [11:0] trim_next;
	logic signed [12:0] pos_next;
	logic               emit;

	assign ch_ok    = int'(channel_s1) < CHANNELS;
	assign key      = {channel_s1, button_s1};
	assign joy_cur  = joy_q[channel_s1];
	assign trim_cur = trim_q[channel_s1];
	assign pos_cur  = pos_q[channel_s1];

	// joystick: keep the sample only if it moved by more than the tolerance
	assign joy_diff = $signed({1'b0, pot_s1}) - $signed({1'b0, joy_cur});
	assign joy_dist = joy_diff[10] ? 11'(-joy_diff) : 11'(joy_diff);
	assign joy_move = joy_dist > {1'b0, noise_tol_q};

	// debounce: a level change restarts the timer, so it cannot settle this request
	assign level_changed = level_s1 != prev_q[key];
	assign elapsed       = time_s1 - change_q[key];
	assign settled       = !level_changed && (elapsed > {16'b0, debounce_q});
	assign new_level     = settled && (level_s1 != stable_q[key]);
	assign press         = new_level && level_s1;

	// trim step on a debounced press, limited by position and trim range
	always_comb begin
		trim_adj = trim_cur;
		if (!button_s1) begin
			if (pos_cur < POS_TOP && trim_cur < TRIM_MAX) begin
				trim_adj = trim_cur + 12'sd1;
			end
		end else begin
			if (pos_cur > POS_BOTTOM && trim_cur > TRIM_MIN) begin
				trim_adj = trim_cur - 12'sd1;
			end
		end
	end

	assign joy_next  = mode_s1 ? joy_cur : pot_s1;
	assign trim_next = mode_s1 ? trim_adj : trim_cur;
	assign pos_next  = $signed({3'b000, joy_next}) + $signed({trim_next[11], trim_next});
	assign emit      = ch_ok && (mode_s1 ? press : joy_move);

	// frame buffer: one frame in flight, sent byte by byte
	logic        frame_valid_q;
	logic [1:0]  byte_q;
	logic        frame_ch_q;
	logic [12:0] frame_pos_q;
	logic        out_accept;
	logic        frame_done;
	logic        buf_free;

	assign out_accept = frame_valid_q && !out_stall;
	assign frame_done = out_accept && (byte_q == BYTE_HIGH);
	assign buf_free   = !frame_valid_q || frame_done;

	// a request that emits nothing never waits on the output side
	assign fire     = valid_s1 && (!emit || buf_free);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USED; i++) begin
				joy_q[i]  <= '0;
				trim_q[i] <= '0;
				pos_q[i]  <= '0;
			end
			for (int i = 0; i < KEYS; i++) begin
				stable_q[i] <= 1'b0;
				prev_q[i]   <= 1'b0;
				change_q[i] <= '0;
			end
		end else if (fire && ch_ok) begin
			if (!mode_s1) begin
				if (joy_move) begin
					joy_q[channel_s1] <= pot_s1;
					pos_q[channel_s1] <= pos_next;
				end
			end else begin
				if (level_changed) begin
					change_q[key] <= time_s1;
				end
				prev_q[key] <= level_s1;
				if (new_level) begin
					stable_q[key] <= level_s1;
				end
				if (press) begin
					trim_q[channel_s1] <= trim_next;
					pos_q[channel_s1]  <= pos_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
			byte_q        <= BYTE_LETTER;
		end else if (fire && emit) begin
			frame_valid_q <= 1'b1;
			byte_q        <= BYTE_LETTER;
		end else if (frame_done) begin
			frame_valid_q <= 1'b0;
		end else if (out_accept) begin
			byte_q <= byte_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			frame_ch_q  <= channel_s1;
			frame_pos_q <= pos_next;
		end
	end

	// byte select; high byte carries the sign of the 16-bit position
	always_comb begin
		unique case (byte_q)
			BYTE_LETTER: frame_byte = LETTER_BASE + {7'b0, frame_ch_q};
			BYTE_LOW:    frame_byte = frame_pos_q[7:0];
			BYTE_HIGH:   frame_byte = {{3{frame_pos_q[12]}}, frame_pos_q[12:8]};
			default:     frame_byte = '0;
		endcase
	end

	assign out_valid = frame_valid_q;
	assign last      = byte_q == BYTE_HIGH;

endmodule

// ===== rtl/rctf_checker.sv =====
`include "rc_channel_trim_and_frame_defines.svh"

module rctf_checker import rctf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       last
);

	// a stalled byte holds
	`RCTF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(frame_byte) && $stable(last))

	// a frame is sent without gaps once started
	`RCTF_ASSERT_NEXT(a_frame_contiguous, clk, arst_n, out_valid && !out_stall && !last,
		out_valid)

	// after a closing byte, the next byte shown opens a frame with a channel letter
	`RCTF_ASSERT_NEXT(a_frame_opens_letter, clk, arst_n, out_valid && !out_stall && last,
		!out_valid || (!last &&
		(frame_byte == LETTER_BASE || frame_byte == LETTER_BASE + 8'd1)))

	// the high byte is a sign extension of a 13-bit position
	`RCTF_ASSERT_IMP(a_high_byte_sign, clk, arst_n, out_valid && last,
		frame_byte[7:5] == 3'b000 || frame_byte[7:5] == 3'b111)

endmodule

bind rc_channel_trim_and_frame rctf_checker u_rctf_checker (.*);

// ===== dv/tb.sv =====
module tb;
	import rctf_pkg::*;

	// no-progress limit: the longest quiet stretch in a correct run is a sender gap,
	// a receiver stall run or a drain plus settle pause
	localparam int WATCHDOG_LIMIT = 2000;
	// cycles let pass after the last expected byte before touching the registers
	localparam int SETTLE_CYCLES  = 4;
	localparam int USE_MODEL      = -1;
	localparam int PHASE_ITEMS    = 34;

	localparam logic MODE_STICK  = 1'b0;
	localparam logic MODE_BUTTON = 1'b1;
	localparam logic BTN_UP      = 1'b0;
	localparam logic BTN_DOWN    = 1'b1;

	typedef struct packed {
		logic        mode;
		logic        ch;
		logic        btn;
		logic [9:0]  pot;
		logic        lvl;
		logic [31:0] t;
	} request_t;

	typedef struct packed {
		logic [7:0] fb;
		logic       lst;
	} frame_byte_t;

	// one row of the directed table; want_n of USE_MODEL means the predictor decides
	typedef struct {
		request_t         req;
		int               want_n;
		logic [2:0][7:0]  want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic                  cfg_index    = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  mode         = 1'b0;
	logic                  channel      = 1'b0;
	logic                  button       = 1'b0;
	logic [9:0]            pot_value    = '0;
	logic                  button_level = 1'b0;
	logic [31:0]           time_ms      = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [7:0]            frame_byte;
	logic                  last;

	rc_channel_trim_and_frame uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.channel      (channel),
		.button       (button),
		.pot_value    (pot_value),
		.button_level (button_level),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.last         (last)
	);

	// shadow copy of the block: registers and per-channel / per-button state
	logic [9:0]         tol_m;
	logic [15:0]        deb_m;
	logic [9:0]         joy_m   [2];
	logic signed [11:0] trim_m  [2];
	logic signed [12:0] pos_m   [2];
	logic               stable_m[4];
	logic               prev_m  [4];
	logic [31:0]        chg_m   [4];

	frame_byte_t pending_bytes[$];
	dir_row_t    dir_rows[$];

	int          errors      = 0;
	int          items_sent  = 0;
	int          burst_left  = 0;
	int          quiet_cycles = 0;
	int          stall_left  = 0;
	logic        stall_on    = 1'b0;
	logic [31:0] now_ms      = 32'd1000;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// work out the frame a request causes and advance the shadow state
	function automatic int frame_for_request(input request_t r, output logic [2:0][7:0] fb);
		int          d;
		int          k;
		int          p;
		logic [31:0] el;
		logic [31:0] pv;
		fb = '0;
		if (r.mode == MODE_STICK) begin
			d = int'(r.pot) - int'(joy_m[r.ch]);
			if (d < 0) d = -d;
			// change must exceed the tolerance, equal is still noise
			if (d <= int'(tol_m)) return 0;
			joy_m[r.ch] = r.pot;
		end else begin
			k = int'({r.ch, r.btn});
			// any level change restarts the debounce window
			if (r.lvl != prev_m[k]) chg_m[k] = r.t;
			prev_m[k] = r.lvl;
			// elapsed time wraps modulo 2^32
			el = r.t - chg_m[k];
			if (el <= {16'd0, deb_m} || r.lvl == stable_m[k]) return 0;
			stable_m[k] = r.lvl;
			// falling edge only moves the debounced level
			if (!r.lvl) return 0;
			if (r.btn == BTN_UP) begin
				if (pos_m[r.ch] < POS_TOP && trim_m[r.ch] < TRIM_MAX)
					trim_m[r.ch] = trim_m[r.ch] + 12'sd1;
			end else begin
				if (pos_m[r.ch] > POS_BOTTOM && trim_m[r.ch] > TRIM_MIN)
					trim_m[r.ch] = trim_m[r.ch] - 12'sd1;
			end
			// a press with no room left still sends a frame
		end
		p = int'(joy_m[r.ch]) + int'(trim_m[r.ch]);
		pv = p;
		pos_m[r.ch] = pv[12:0];
		fb[0] = LETTER_BASE + {7'd0, r.ch};
		fb[1] = pv[7:0];
		fb[2] = pv[15:8];
		return 3;
	endfunction

	// present one request, hold it until taken, then queue the bytes it must produce
	task automatic send_req(input request_t r, input int want_n, input logic [2:0][7:0] want);
		int              n;
		logic [2:0][7:0] fb;
		mode         <= r.mode;
		channel      <= r.ch;
		button       <= r.btn;
		pot_value    <= r.pot;
		button_level <= r.lvl;
		time_ms      <= r.t;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n = frame_for_request(r, fb);
		// typed rows override the predicted bytes, the shadow state still advances
		if (want_n != USE_MODEL) begin
			n = want_n;
			fb = want;
		end
		for (int i = 0; i < n; i++) pending_bytes.push_back({fb[i], i == 2});
		items_sent++;
		// bursts of back-to-back requests separated by random gaps
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic send_item(input logic m, input logic c, input logic b, input logic [9:0] pot,
			input logic lvl, input logic [31:0] t);
		send_req({m, c, b, pot, lvl, t}, USE_MODEL, '0);
	endtask

	task automatic add_row(input logic m, input logic c, input logic b, input logic [9:0] pot,
			input logic lvl, input logic [31:0] t, input int n,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		dir_row_t row;
		row.req = {m, c, b, pot, lvl, t};
		row.want_n = n;
		row.want = {b2, b1, b0};
		dir_rows.push_back(row);
	endtask

	// stop sending until every expected byte is out, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == REG_NOISE_TOL) tol_m = data[9:0];
		else deb_m = data;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// time steps: short ones stay inside the debounce window, long ones leave it
	function automatic logic [31:0] short_step();
		return $urandom_range(0, int'(deb_m));
	endfunction

	function automatic logic [31:0] long_step();
		return {16'd0, deb_m} + 32'd1 + $urandom_range(0, 30);
	endfunction

	// a full button press: optional contact bounce, a held high, usually a held release
	task automatic send_press(input logic c, input logic b);
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				now_ms += short_step();
				send_item(MODE_BUTTON, c, b, 10'($urandom), 1'($urandom), now_ms);
			end
		end
		now_ms += short_step();
		send_item(MODE_BUTTON, c, b, 10'($urandom), 1'b1, now_ms);
		now_ms += long_step();
		send_item(MODE_BUTTON, c, b, 10'($urandom), 1'b1, now_ms);
		if ($urandom_range(0, 3) != 0) begin
			now_ms += short_step();
			send_item(MODE_BUTTON, c, b, 10'($urandom), 1'b0, now_ms);
			now_ms += long_step();
			send_item(MODE_BUTTON, c, b, 10'($urandom), 1'b0, now_ms);
		end
	endtask

	task automatic run_random(input int count);
		int          goal;
		int          pick;
		int          d;
		int          target;
		logic        c;
		logic [31:0] t;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 9);
			c = 1'($urandom);
			if (pick <= 3) begin
				// joystick: anywhere, right at the tolerance edge, or at the rails
				case ($urandom_range(0, 2))
					0: target = $urandom_range(0, 1023);
					1: begin
						d = int'(tol_m) + int'($urandom_range(0, 3)) - 1;
						target = $urandom_range(0, 1) ? int'(joy_m[c]) + d : int'(joy_m[c]) - d;
						if (target < 0) target = 0;
						if (target > 1023) target = 1023;
					end
					default: target = $urandom_range(0, 1) ? 1023 : 0;
				endcase
				send_item(MODE_STICK, c, 1'($urandom), 10'(target), 1'($urandom), $urandom);
			end else if (pick <= 7) begin
				send_press(c, 1'($urandom));
			end else begin
				// stray button sample, at a wild time or just after the last one
				t = $urandom_range(0, 1) ? $urandom : now_ms + short_step();
				send_item(MODE_BUTTON, c, 1'($urandom), 10'($urandom), 1'($urandom), t);
			end
			if ($urandom_range(0, 39) == 0) wait_drained();
		end
	endtask

	// receiver: stall runs and free runs of random length
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_on = ($urandom_range(0, 2) == 0);
			stall_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 24);
		end
		stall_left--;
		out_stall <= stall_on;
	end

	// frame byte checker
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				if (errors < 10) $display("unexpected frame byte %h last %b", frame_byte, last);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (frame_byte !== want.fb || last !== want.lst) begin
					if (errors < 10)
						$display("frame byte mismatch: expected %h last %b, got %h last %b",
							want.fb, want.lst, frame_byte, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles where neither channel moves anything
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] tol_w;
		logic [CFG_DATA_W-1:0] deb_w;

		tol_m = NOISE_TOL_RESET;
		deb_m = DEBOUNCE_RESET;
		for (int i = 0; i < 2; i++) begin
			joy_m[i] = '0;
			trim_m[i] = '0;
			pos_m[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			stable_m[i] = 1'b0;
			prev_m[i] = 1'b0;
			chg_m[i] = '0;
		end

		// directed table, reset registers: tolerance 10, debounce 50
		// joystick inside tolerance from reset value
		add_row(MODE_STICK, 1'b0, BTN_UP, 10'd5, 1'b0, 32'd0, 0, 8'h00, 8'h00, 8'h00);
		// full-scale jump, unused button fields set and time at its top
		add_row(MODE_STICK, 1'b0, BTN_DOWN, 10'd1023, 1'b1, 32'hFFFF_FFFF, 3,
			8'h41, 8'hFF, 8'h03);
		add_row(MODE_STICK, 1'b1, BTN_UP, 10'd0, 1'b0, 32'd0, 0, 8'h00, 8'h00, 8'h00);
		// one past the tolerance
		add_row(MODE_STICK, 1'b1, BTN_UP, 10'd11, 1'b0, 32'd0, 3, 8'h42, 8'h0B, 8'h00);
		// exactly at the tolerance is still noise
		add_row(MODE_STICK, 1'b1, BTN_UP, 10'd21, 1'b0, 32'd0, 0, 8'h00, 8'h00, 8'h00);
		// trim-up press with the position already at the top
		add_row(MODE_BUTTON, 1'b0, BTN_UP, 10'd0, 1'b1, 32'd100, USE_MODEL, 8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_UP, 10'd0, 1'b1, 32'd150, 0, 8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_UP, 10'd0, 1'b1, 32'd151, 3, 8'h41, 8'hFF, 8'h03);
		// release: falling edge gives no frame
		add_row(MODE_BUTTON, 1'b0, BTN_UP, 10'd0, 1'b0, 32'd160, USE_MODEL, 8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_UP, 10'd0, 1'b0, 32'd300, 0, 8'h00, 8'h00, 8'h00);
		// trim-down press
		add_row(MODE_BUTTON, 1'b0, BTN_DOWN, 10'd1023, 1'b1, 32'd400, USE_MODEL,
			8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_DOWN, 10'd1023, 1'b1, 32'd500, 3, 8'h41, 8'hFE, 8'h03);
		// joystick to zero with negative trim: position goes negative
		add_row(MODE_STICK, 1'b0, BTN_UP, 10'd0, 1'b0, 32'd500, 3, 8'h41, 8'hFF, 8'hFF);
		// debounce window across the timer wrap
		add_row(MODE_BUTTON, 1'b1, BTN_UP, 10'd0, 1'b1, 32'hFFFF_FFF0, USE_MODEL,
			8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b1, BTN_UP, 10'd0, 1'b1, 32'h0000_0030, 3, 8'h42, 8'h0C, 8'h00);
		add_row(MODE_BUTTON, 1'b1, BTN_UP, 10'd0, 1'b0, 32'h0000_0040, USE_MODEL,
			8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b1, BTN_UP, 10'd0, 1'b0, 32'h0000_0100, 0, 8'h00, 8'h00, 8'h00);
		// trim-down press with the position already below zero
		add_row(MODE_BUTTON, 1'b0, BTN_DOWN, 10'd0, 1'b0, 32'd600, USE_MODEL,
			8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_DOWN, 10'd0, 1'b0, 32'd700, 0, 8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_DOWN, 10'd0, 1'b1, 32'd800, USE_MODEL,
			8'h00, 8'h00, 8'h00);
		add_row(MODE_BUTTON, 1'b0, BTN_DOWN, 10'd0, 1'b1, 32'd900, 3, 8'h41, 8'hFF, 8'hFF);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].want_n, dir_rows[i].want);

		// random phases, each under its own register setting, extremes included
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin tol_w = 16'd0;    deb_w = 16'd0;     end
				1: begin tol_w = 16'd1023; deb_w = 16'd65535; end
				2: begin tol_w = {6'($urandom), 10'($urandom)}; deb_w = 16'($urandom); end
				3: begin tol_w = 16'd3;    deb_w = 16'd20;    end
				4: begin tol_w = 16'd1023; deb_w = 16'd0;     end
				5: begin tol_w = 16'd0;    deb_w = 16'd65535; end
				default: begin tol_w = 16'd10; deb_w = 16'd50; end
			endcase
			// registers only change with the block idle
			wait_drained();
			cfg_write(REG_NOISE_TOL, tol_w);
			cfg_write(REG_DEBOUNCE, deb_w);
			run_random(PHASE_ITEMS);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_bytes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rctf_pkg.sv
rtl/rc_channel_trim_and_frame.sv
rtl/rctf_checker.sv
dv/tb.sv
